// ===== hdl/utf8_stream_decoder_defines.svh =====
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define U8D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8d assertion failed");

// Next-cycle implication, checked out of reset.
`define U8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8d assertion failed");

// Condition that must never hold.
`define U8D_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("u8d assertion failed");

`endif

// ===== hdl/u8d_pkg.sv =====
// Types, constants and decode function of the UTF-8 stream decoder.
`default_nettype none
package u8d_pkg;

    localparam int CP_W    = 21;
    localparam int MAX_RES = 4;
    localparam int HOLD_N  = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    typedef struct packed {
        logic [2:0]                     cnt;
        logic [MAX_RES-1:0][CP_W-1:0]   cp;
    } t_entry;

    typedef struct packed {
        t_entry                     ent;
        logic [HOLD_N-1:0][7:0]     held;
        logic [1:0]                 held_cnt;
    } t_dec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80)                   len = 3'd1;
        else if ((b & 8'hE0) == 8'hC0)   len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0)   len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0)   len = 3'd4;
        else                             len = 3'd1;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    // Decodes up to four bytes (held ones plus the new one) in one pass.
    function automatic t_dec dec_step(input logic [3:0][7:0] bb, input logic [2:0] n,
                                      input logic fin);
        t_dec       d;
        logic [2:0] i;
        logic       stop;
        logic [2:0] len;
        logic [7:0] c0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       ok;
        logic [CP_W-1:0] cp;
        logic [2:0] ix;
        d    = '0;
        i    = '0;
        stop = 1'b0;
        for (int s = 0; s < MAX_RES; s++) begin
            if (!stop && (i < n)) begin
                c0  = bb[i[1:0]];
                len = seq_len(c0);
                ix  = i + 3'd1;
                b1  = bb[ix[1:0]];
                ix  = i + 3'd2;
                b2  = bb[ix[1:0]];
                ix  = i + 3'd3;
                b3  = bb[ix[1:0]];
                cp  = REPL_CP;
                if (len == 3'd1) begin
                    if (c0 < 8'h80) cp = {13'd0, c0};
                    i = i + 3'd1;
                end else if ((i + len) > n) begin
                    stop = 1'b1;
                    if (!fin) begin
                        for (int j = 0; j < HOLD_N; j++) begin
                            ix = i + 3'(j);
                            if (3'(j) < (n - i)) d.held[j] = bb[ix[1:0]];
                        end
                        d.held_cnt = 2'(n - i);
                    end
                end else begin
                    ok = is_cont(b1);
                    if (len >= 3'd3) ok = ok & is_cont(b2);
                    if (len == 3'd4) ok = ok & is_cont(b3);
                    if (!ok) begin
                        i = i + 3'd1;
                    end else begin
                        case (len)
                            3'd2: cp = {10'd0, c0[4:0], b1[5:0]};
                            3'd3: cp = {5'd0, c0[3:0], b1[5:0], b2[5:0]};
                            default: cp = {c0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                        endcase
                        i = i + len;
                    end
                end
                if (!stop || fin) begin
                    if (d.ent.cnt < 3'(MAX_RES)) begin
                        d.ent.cp[d.ent.cnt[1:0]] = cp;
                        d.ent.cnt = d.ent.cnt + 3'd1;
                    end
                end
            end
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/u8d_front.sv =====
// Front part: takes bytes, keeps held bytes, decodes one byte's results into an entry.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module u8d_front
    import u8d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_fin,
    input  wire t_qstat     i_qstat,
    output logic            o_push,
    output t_entry          o_entry
);

    logic [HOLD_N-1:0][7:0] r_held;
    logic [1:0]             r_held_cnt;
    logic [3:0][7:0]        w_buf;
    logic [2:0]             w_n;
    t_dec                   w_dec;
    logic                   w_acc;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (2'(j) < r_held_cnt && j < HOLD_N) w_buf[j] = r_held[j % HOLD_N];
            else if (3'(j) == {1'b0, r_held_cnt}) w_buf[j] = i_byte;
            else w_buf[j] = 8'h00;
        end
        w_n   = {1'b0, r_held_cnt} + 3'd1;
        w_dec = dec_step(w_buf, w_n, i_fin);
    end

    assign o_ready = !i_qstat.full;
    assign w_acc   = i_valid && o_ready;
    assign o_push  = w_acc && (w_dec.ent.cnt != 3'd0);
    assign o_entry = w_dec.ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= '0;
        end else if (w_acc) begin
            r_held_cnt <= w_dec.held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_held <= w_dec.held;
    end

    `U8D_ASSERT_NEXT(a_fin_clears_hold, i_clk, i_rst_n, w_acc && i_fin, r_held_cnt == 2'd0)

endmodule
`default_nettype wire

// ===== hdl/u8d_queue.sv =====
// Short queue of decoded entries between the front and back parts.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module u8d_queue
    import u8d_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output t_qstat      o_stat
);

    t_entry             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr;
    logic [Q_AW-1:0]    r_rd;
    logic [Q_AW:0]      r_cnt;

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + Q_AW'(1);
            if (i_pop)  r_rd <= r_rd + Q_AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    `U8D_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_stat.full)
    `U8D_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_stat.empty)

endmodule
`default_nettype wire

// ===== hdl/u8d_back.sv =====
// Back part: walks each entry's code points into the output register.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module u8d_back
    import u8d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_entry     i_head,
    input  wire t_qstat     i_qstat,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [CP_W-1:0] o_cp,
    output logic            o_last
);

    logic [1:0]         r_sub;
    logic               r_valid;
    logic [CP_W-1:0]    r_cp;
    logic               r_last;
    logic               w_adv;
    logic               w_take;
    logic               w_end;

    assign w_adv  = !r_valid || i_ready;
    assign w_take = w_adv && !i_qstat.empty;
    assign w_end  = ({1'b0, r_sub} == (i_head.cnt - 3'd1));
    assign o_pop  = w_take && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= '0;
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= !i_qstat.empty;
            if (w_take) r_sub <= w_end ? 2'd0 : r_sub + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cp   <= i_head.cp[r_sub];
            r_last <= w_end;
        end
    end

    assign o_valid = r_valid;
    assign o_cp    = r_cp;
    assign o_last  = r_last;

    `U8D_ASSERT_IMPL(a_sub_in_range, i_clk, i_rst_n, !i_qstat.empty,
                     {1'b0, r_sub} < i_head.cnt)

endmodule
`default_nettype wire

// ===== hdl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front part, entry queue, back part.
//
//  channel | dir | tdata                  | tlast      | tuser
//  s_axis  | in  | [7:0] text_byte        | final_byte | -
//  m_axis  | out | [20:0] code_point      | run_last   | -
//
// A byte is taken every cycle while the four-entry queue has room.
// Each byte yields 0 to 4 code points; the back part sends one per cycle while m_axis_tready is high.
// Sustained rate while m_axis_tready stays high: one byte per cycle at one
// result per byte, else set by the output side at one code point per cycle.
// Reset clears the held-byte count, queue pointers and output valid.
// Output stalls fill the queue, after which s_axis_tready drops.
`default_nettype none
module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_axis_tlast
);

    t_qstat             w_qstat;
    t_entry             w_push_ent;
    t_entry             w_head;
    logic               w_push;
    logic               w_pop;
    logic [CP_W-1:0]    w_cp;

    u8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_fin   (s_axis_tlast),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_push_ent)
    );

    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_ent),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    u8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_cp    (w_cp),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, w_cp};

endmodule
`default_nettype wire
